[rtl/deadline_sorted_sleep_queue_defines.svh]
// Assertion helpers for the sleep queue.
`ifndef DEADLINE_SORTED_SLEEP_QUEUE_DEFINES_SVH
`define DEADLINE_SORTED_SLEEP_QUEUE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define DSSQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define DSSQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[rtl/dssq_pkg.sv]
`default_nettype none

package dssq_pkg;

  // Field widths fixed by the interface
  localparam int DELAY_W = 32;
  localparam int RATE_W  = 20;
  localparam int TICK_W  = 64;

  // Millisecond to tick conversion: floor(x / 1000) is (x * RECIP_1000) >> RECIP_SHIFT,
  // exact for every x below 2^32
  localparam int MS_PER_S    = 1000;
  localparam int REM_W       = 10;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(274877907);
  localparam int QUOT_W      = DELAY_W + RECIP_W - RECIP_SHIFT;
  localparam int WHOLE_W     = QUOT_W + RATE_W;
  localparam int PART_W      = REM_W + RATE_W;
  localparam int FRAC_W      = PART_W + RECIP_W - RECIP_SHIFT;
  localparam int CONV_STAGES = 6;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  // Input function codes
  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WOKEN    = 2'd0,
    KIND_INSERTED = 2'd1,
    KIND_YIELD    = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_POP
  } state_e;

endpackage

`default_nettype wire

[rtl/dssq_wake.sv]
`default_nettype none

module dssq_wake (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [dssq_pkg::DELAY_W-1:0] delay_ms_i,
  input  logic [dssq_pkg::RATE_W-1:0]  rate_i,
  input  logic [dssq_pkg::TICK_W-1:0]  now_i,
  output logic                         done_o,
  output logic [dssq_pkg::TICK_W-1:0]  wake_o
);
  import dssq_pkg::*;

  localparam int APROD_W = DELAY_W + RECIP_W;
  localparam int FPROD_W = PART_W + RECIP_W;

  logic [APROD_W-1:0]     a_prod;
  logic [FPROD_W-1:0]     f_prod;
  logic [QUOT_W-1:0]      quot_q;
  logic [REM_W-1:0]       dly_lo_q, rem_d, rem_q;
  logic [RATE_W-1:0]      rt_q;
  logic [TICK_W-1:0]      now_q;
  logic [WHOLE_W-1:0]     whole_q;
  logic [PART_W-1:0]      part_q;
  logic [FRAC_W-1:0]      frac_q;
  logic [TICK_W-1:0]      tsum, ticks_q, wake_q, wake_d;
  logic [TICK_W:0]        sum;
  logic [CONV_STAGES-1:0] pipe_q;

  // Whole seconds of delay by reciprocal multiply
  assign a_prod = APROD_W'(delay_ms_i) * APROD_W'(RECIP_1000);

  // Leftover milliseconds, below 1000 so the low bits suffice
  assign rem_d = dly_lo_q - REM_W'(quot_q) * REM_W'(MS_PER_S);

  // Ticks from the leftover milliseconds, again by reciprocal multiply
  assign f_prod = FPROD_W'(part_q) * FPROD_W'(RECIP_1000);

  // Clamp to one tick, add and saturate
  assign tsum   = TICK_W'(whole_q) + TICK_W'(frac_q);
  assign sum    = {1'b0, now_q} + {1'b0, ticks_q};
  assign wake_d = sum[TICK_W] ? '1 : sum[TICK_W-1:0];

  // Track the item through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= {pipe_q[CONV_STAGES-2:0], go_i};
    end
  end

  // Capture the item, then advance the stages every cycle
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quot_q   <= a_prod[APROD_W-1:RECIP_SHIFT];
      dly_lo_q <= delay_ms_i[REM_W-1:0];
      rt_q     <= rate_i;
      now_q    <= now_i;
    end
    rem_q   <= rem_d;
    whole_q <= WHOLE_W'(quot_q) * WHOLE_W'(rt_q);
    part_q  <= PART_W'(rem_q) * PART_W'(rt_q);
    frac_q  <= f_prod[FPROD_W-1:RECIP_SHIFT];
    ticks_q <= (tsum == '0) ? TICK_W'(1) : tsum;
    wake_q  <= wake_d;
  end

  assign done_o = pipe_q[CONV_STAGES-1];
  assign wake_o = wake_q;

endmodule

`default_nettype wire

[rtl/dssq_cell.sv]
`default_nettype none

module dssq_cell #(
  parameter int ID_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dssq_pkg::cell_op_e          op_i,
  input  logic [dssq_pkg::TICK_W-1:0] key_i,
  input  logic [ID_W-1:0]             new_task_i,
  input  logic                        left_valid_i,
  input  logic                        left_le_i,
  input  logic [dssq_pkg::TICK_W-1:0] left_wake_i,
  input  logic [ID_W-1:0]             left_task_i,
  input  logic                        right_valid_i,
  input  logic [dssq_pkg::TICK_W-1:0] right_wake_i,
  input  logic [ID_W-1:0]             right_task_i,
  output logic                        valid_o,
  output logic                        le_o,
  output logic [dssq_pkg::TICK_W-1:0] wake_o,
  output logic [ID_W-1:0]             task_o
);
  import dssq_pkg::*;

  logic              valid_q, valid_d;
  logic [TICK_W-1:0] wake_q, wake_d;
  logic [ID_W-1:0]   task_q, task_d;
  logic              le;

  // Entry is due or sorts before the key
  assign le = valid_q && (wake_q <= key_i);

  // Hold, take the new entry, or shift from a neighbour
  always_comb begin
    valid_d = valid_q;
    wake_d  = wake_q;
    task_d  = task_q;
    case (op_i)
      OP_INSERT: begin
        if (!left_le_i) begin
          valid_d = left_valid_i;
          wake_d  = left_wake_i;
          task_d  = left_task_i;
        end else if (!le) begin
          valid_d = 1'b1;
          wake_d  = key_i;
          task_d  = new_task_i;
        end
      end
      OP_POP: begin
        valid_d = right_valid_i;
        wake_d  = right_wake_i;
        task_d  = right_task_i;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wake_q <= wake_d;
    task_q <= task_d;
  end

  assign valid_o = valid_q;
  assign le_o    = le;
  assign wake_o  = wake_q;
  assign task_o  = task_q;

endmodule

`default_nettype wire

[rtl/deadline_sorted_sleep_queue.sv]
// Sleep request: the tick conversion pipeline (reciprocal divide by 1000, clamp to one
// tick, saturating add) then the result register give the result; busy until then.
// Yield: result in the next cycle. Timer tick: one cell-chain shift per woken task,
// one result per cycle; busy until the last due task has been popped from the head.
// Results cannot be stalled. Reset empties the queue at once and sets the rate to 1000.
`default_nettype none
`include "deadline_sorted_sleep_queue_defines.svh"

module deadline_sorted_sleep_queue #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dssq_pkg::RATE_W-1:0]  cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         func_i,
  input  logic [TASK_ID_BITS-1:0]      task_id_i,
  input  logic [dssq_pkg::DELAY_W-1:0] delay_ms_i,
  input  logic [dssq_pkg::TICK_W-1:0]  now_tick_i,
  output logic                         result_valid_o,
  output dssq_pkg::kind_e              kind_o,
  output logic [TASK_ID_BITS-1:0]      woken_id_o,
  output logic [dssq_pkg::TICK_W-1:0]  wake_at_o,
  output logic                         last_o
);
  import dssq_pkg::*;

  state_e            state_q, state_d;
  logic [RATE_W-1:0] rate_q;
  logic [TASK_ID_BITS-1:0] pend_id_q;
  logic [TICK_W-1:0] tick_now_q;

  logic              accept;
  logic              wake_go, wake_done;
  logic [TICK_W-1:0] wake_val;
  logic [TICK_W-1:0] key;
  cell_op_e          op;
  logic              full;

  logic                    res_valid_q, res_valid_d;
  kind_e                   kind_q, kind_d;
  logic [TASK_ID_BITS-1:0] id_q, id_d;
  logic [TICK_W-1:0]       wake_at_q, wake_at_d;
  logic                    last_q, last_d;

  logic [QUEUE_DEPTH-1:0]  cell_valid, cell_le, valid_inc;
  logic [TICK_W-1:0]       cell_wake [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] cell_task [QUEUE_DEPTH];

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign full   = cell_valid[QUEUE_DEPTH-1];
  assign key    = (state_q == ST_POP) ? tick_now_q : wake_val;

  // Tick conversion unit
  dssq_wake u_wake (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (wake_go),
    .delay_ms_i (delay_ms_i),
    .rate_i     (rate_q),
    .now_i      (now_tick_i),
    .done_o     (wake_done),
    .wake_o     (wake_val)
  );

  // Sorted chain, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                    l_valid, l_le, r_valid;
    logic [TICK_W-1:0]       l_wake, r_wake;
    logic [TASK_ID_BITS-1:0] l_task, r_task;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_le    = 1'b1;
      assign l_wake  = '0;
      assign l_task  = '0;
    end else begin : g_body
      assign l_valid = cell_valid[i-1];
      assign l_le    = cell_le[i-1];
      assign l_wake  = cell_wake[i-1];
      assign l_task  = cell_task[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_wake  = '0;
      assign r_task  = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_wake  = cell_wake[i+1];
      assign r_task  = cell_task[i+1];
    end

    dssq_cell #(
      .ID_W (TASK_ID_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .key_i         (key),
      .new_task_i    (pend_id_q),
      .left_valid_i  (l_valid),
      .left_le_i     (l_le),
      .left_wake_i   (l_wake),
      .left_task_i   (l_task),
      .right_valid_i (r_valid),
      .right_wake_i  (r_wake),
      .right_task_i  (r_task),
      .valid_o       (cell_valid[i]),
      .le_o          (cell_le[i]),
      .wake_o        (cell_wake[i]),
      .task_o        (cell_task[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_TICK) begin
            state_d = ST_POP;
          end else if (delay_ms_i != '0) begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (wake_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (!cell_le[0] || !cell_le[1]) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Chain operation and result
  always_comb begin
    op          = OP_HOLD;
    wake_go     = 1'b0;
    res_valid_d = 1'b0;
    kind_d      = KIND_WOKEN;
    id_d        = pend_id_q;
    wake_at_d   = '0;
    last_d      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_SLEEP)) begin
          if (delay_ms_i == '0) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_YIELD;
            id_d        = task_id_i;
          end else begin
            wake_go = 1'b1;
          end
        end
      end
      ST_CALC: begin
        if (wake_done) begin
          res_valid_d = 1'b1;
          wake_at_d   = wake_val;
          if (full) begin
            kind_d = KIND_FULL;
          end else begin
            kind_d = KIND_INSERTED;
            op     = OP_INSERT;
          end
        end
      end
      ST_POP: begin
        if (cell_le[0]) begin
          op          = OP_POP;
          res_valid_d = 1'b1;
          kind_d      = KIND_WOKEN;
          id_d        = cell_task[0];
          wake_at_d   = cell_wake[0];
          last_d      = !cell_le[1];
        end
      end
      default: op = OP_HOLD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RATE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_id_q  <= task_id_i;
      tick_now_q <= now_tick_i;
    end
    if (res_valid_d) begin
      kind_q    <= kind_d;
      id_q      <= id_d;
      wake_at_q <= wake_at_d;
      last_q    <= last_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign woken_id_o     = id_q;
  assign wake_at_o      = wake_at_q;
  assign last_o         = last_q;

  assign valid_inc = cell_valid + QUEUE_DEPTH'(1);

  `DSSQ_ASSERT(a_valid_prefix, clk_i, rst_ni, (cell_valid & valid_inc) == '0, "holes in queue")
  `DSSQ_ASSERT(a_pop_shrinks, clk_i, rst_ni,
               (result_valid_o && kind_o == KIND_WOKEN) |->
               ($countones(cell_valid) + 1 == $countones($past(cell_valid))),
               "pop count mismatch")
  `DSSQ_ASSERT(a_insert_grows, clk_i, rst_ni,
               (result_valid_o && kind_o == KIND_INSERTED) |->
               ($countones(cell_valid) == $countones($past(cell_valid)) + 1),
               "insert count mismatch")
  `DSSQ_ASSERT_NEVER(a_full_flag, clk_i, rst_ni,
                     result_valid_o && kind_o == KIND_FULL && !full,
                     "full flagged on free queue")

endmodule

`default_nettype wire
